FILE: rtl/li_chao_min_line_tree_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Li Chao minimum line tree
// Concurrent checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef LI_CHAO_MIN_LINE_TREE_TOP_ASSERT_SVH
`define LI_CHAO_MIN_LINE_TREE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define LCT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lct check failed");
`define LCT_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`else
`define LCT_ASSERT(lbl, prop)
`define LCT_ASSERT_MSG(lbl, prop, msg)
`endif
`endif

FILE: rtl/lct_pkg.sv
// ----------------------------------------------------------------------------
// lct_pkg
// Shared constants, datapath commands and status for the Li Chao tree.
// ----------------------------------------------------------------------------
`default_nettype none
package lct_pkg;

  localparam int LEAVES = 1024;
  localparam int LW     = $clog2(LEAVES);  // leaf slot bits
  localparam int NW     = LW + 1;          // node index bits
  localparam int SW     = LW + 2;          // segment bound bits
  localparam int LVW    = $clog2(NW);      // tree level bits
  localparam int CW     = 11;              // coord_count width
  localparam int KW     = 2;
  localparam int EW     = 11;              // end_slot width
  localparam int AW     = 32;              // slope
  localparam int BW     = 61;              // input intercept
  localparam int NBW    = 63;              // stored intercept
  localparam int CRW    = 32;              // coordinate
  localparam int XW     = 33;              // coordinate plus one
  localparam int VW     = 64;              // line value
  localparam int EVALS  = 6;
  localparam int EKW    = 3;

  localparam logic signed [VW-1:0] NO_LINE = 64'sd3000000000000000000;

  localparam logic [KW-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KW-1:0] KIND_LINE  = 2'd1;
  localparam logic [KW-1:0] KIND_SEG   = 2'd2;
  localparam logic [KW-1:0] KIND_QUERY = 2'd3;

  typedef enum logic [4:0] {
    DP_NOP, DP_CLEAR, DP_ACCEPT, DP_INS_L, DP_INS_R, DP_SHIFT,
    DP_RD_NODE, DP_CAP_XL, DP_CAP_XC, DP_CAP_XR, DP_MUL, DP_ADD,
    DP_DECIDE, DP_RD_Q, DP_CAP_Q, DP_CAP_NODE, DP_QADD, DP_OUT
  } lct_op_e;

  typedef enum logic [1:0] {PT_L, PT_C, PT_R, PT_Q} lct_pt_e;

  typedef struct packed {
    lct_op_e op;
    lct_pt_e pt;
  } lct_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic l_lt_r;
    logic l_odd;
    logic r_odd;
    logic k_last;
    logic ins_done;
    logic i_root;
  } lct_sts_t;

endpackage
`default_nettype wire

FILE: rtl/lct_in_if.sv
// ----------------------------------------------------------------------------
// lct_in_if
// Request channel: load, line add, segment add or query.
// ----------------------------------------------------------------------------
`default_nettype none
interface lct_in_if;
  import lct_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [KW-1:0]          kind;
  logic [LW-1:0]          slot;
  logic [EW-1:0]          end_slot;
  logic signed [AW-1:0]   slope;
  logic signed [BW-1:0]   intercept;
  logic signed [CRW-1:0]  coordinate;
  modport source (output valid, kind, slot, end_slot, slope, intercept, coordinate,
                  input ready);
  modport sink   (input valid, kind, slot, end_slot, slope, intercept, coordinate,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/lct_out_if.sv
// ----------------------------------------------------------------------------
// lct_out_if
// Result channel: minimum line value of a query.
// ----------------------------------------------------------------------------
`default_nettype none
interface lct_out_if;
  import lct_pkg::*;
  logic                  valid;
  logic                  ready;
  logic signed [VW-1:0]  min_value;
  modport source (output valid, min_value, input ready);
  modport sink   (input valid, min_value, output ready);
endinterface
`default_nettype wire

FILE: rtl/lct_ram.sv
// ----------------------------------------------------------------------------
// lct_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module lct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

FILE: rtl/lct_ctrl.sv
// ----------------------------------------------------------------------------
// lct_ctrl
// Sequencer: node clear, segment walk, node insertion and query walk.
// ----------------------------------------------------------------------------
`default_nettype none
`include "li_chao_min_line_tree_top_assert.svh"
module lct_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic [lct_pkg::KW-1:0] in_kind_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output lct_pkg::lct_cmd_t        cmd_o,
  input  wire lct_pkg::lct_sts_t   sts_i
);
  import lct_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_SEG_L, S_SEG_R, S_SEG_SH, S_NRD, S_XL, S_XC, S_XR,
    S_MUL, S_ADD, S_DEC, S_QX, S_QXC, S_QN, S_QC, S_QM, S_QA, S_QOUT
  } state_e;

  typedef enum logic [1:0] {RET_DONE, RET_R, RET_SH} ret_e;

  state_e state_q, state_d;
  ret_e   ret_q, ret_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.op    = DP_NOP;
    cmd_o.pt    = PT_L;
    case (state_q)
      S_CLEAR: begin
        cmd_o.op = DP_CLEAR;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cmd_o.op = DP_ACCEPT;
          case (in_kind_i)
            KIND_LINE: begin
              state_d = S_NRD;
              ret_d   = RET_DONE;
            end
            KIND_SEG:   state_d = S_SEG_L;
            KIND_QUERY: state_d = S_QX;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_SEG_L: begin
        if (!sts_i.l_lt_r) begin
          state_d = S_IDLE;
        end else if (sts_i.l_odd) begin
          cmd_o.op = DP_INS_L;
          ret_d    = RET_R;
          state_d  = S_NRD;
        end else begin
          state_d = S_SEG_R;
        end
      end
      S_SEG_R: begin
        if (sts_i.r_odd) begin
          cmd_o.op = DP_INS_R;
          ret_d    = RET_SH;
          state_d  = S_NRD;
        end else begin
          state_d = S_SEG_SH;
        end
      end
      S_SEG_SH: begin
        cmd_o.op = DP_SHIFT;
        state_d  = S_SEG_L;
      end
      S_NRD: begin
        cmd_o.op = DP_RD_NODE;
        cmd_o.pt = PT_L;
        state_d  = S_XL;
      end
      S_XL: begin
        cmd_o.op = DP_CAP_XL;
        cmd_o.pt = PT_C;
        state_d  = S_XC;
      end
      S_XC: begin
        cmd_o.op = DP_CAP_XC;
        cmd_o.pt = PT_R;
        state_d  = S_XR;
      end
      S_XR: begin
        cmd_o.op = DP_CAP_XR;
        state_d  = S_MUL;
      end
      S_MUL: begin
        cmd_o.op = DP_MUL;
        state_d  = S_ADD;
      end
      S_ADD: begin
        cmd_o.op = DP_ADD;
        state_d  = sts_i.k_last ? S_DEC : S_MUL;
      end
      S_DEC: begin
        cmd_o.op = DP_DECIDE;
        if (!sts_i.ins_done) begin
          state_d = S_NRD;
        end else begin
          case (ret_q)
            RET_R:   state_d = S_SEG_R;
            RET_SH:  state_d = S_SEG_SH;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_QX: begin
        cmd_o.op = DP_RD_Q;
        cmd_o.pt = PT_Q;
        state_d  = S_QXC;
      end
      S_QXC: begin
        cmd_o.op = DP_CAP_Q;
        state_d  = S_QN;
      end
      S_QN: begin
        cmd_o.op = DP_RD_NODE;
        cmd_o.pt = PT_Q;
        state_d  = S_QC;
      end
      S_QC: begin
        cmd_o.op = DP_CAP_NODE;
        state_d  = S_QM;
      end
      S_QM: begin
        cmd_o.op = DP_MUL;
        state_d  = S_QA;
      end
      S_QA: begin
        cmd_o.op = DP_QADD;
        state_d  = sts_i.i_root ? S_QOUT : S_QN;
      end
      S_QOUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = DP_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      ret_q       <= RET_DONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      out_valid_q <= out_valid_d;
    end
  end

  `LCT_ASSERT_MSG(a_out_from_qout, $rose(out_valid_q) |-> $past(state_q == S_QOUT),
                  "result raised outside query completion")
  `LCT_ASSERT(a_query_starts, (accept && in_kind_i == KIND_QUERY) |=> state_q == S_QX)
  `LCT_ASSERT(a_qout_holds,
              (state_q == S_QOUT && out_valid_q && !out_ready_i) |=> state_q == S_QOUT)
endmodule
`default_nettype wire

FILE: rtl/lct_dp.sv
// ----------------------------------------------------------------------------
// lct_dp
// Datapath: coordinate table, node store, shared line evaluator, walk state.
// ----------------------------------------------------------------------------
`default_nettype none
`include "li_chao_min_line_tree_top_assert.svh"
module lct_dp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire lct_pkg::lct_cmd_t              cmd_i,
  output lct_pkg::lct_sts_t                   sts_o,
  input  wire logic                           cc_we_i,
  input  wire logic [lct_pkg::CW-1:0]         cc_i,
  input  wire logic [lct_pkg::KW-1:0]         kind_i,
  input  wire logic [lct_pkg::LW-1:0]         slot_i,
  input  wire logic [lct_pkg::EW-1:0]         end_slot_i,
  input  wire logic signed [lct_pkg::AW-1:0]  slope_i,
  input  wire logic signed [lct_pkg::BW-1:0]  intercept_i,
  input  wire logic signed [lct_pkg::CRW-1:0] coordinate_i,
  output logic signed [lct_pkg::VW-1:0]       min_value_o
);
  import lct_pkg::*;

  localparam int NDW = AW + NBW;

  // control state
  logic [CW-1:0]  cc_q;
  logic [NW-1:0]  i_q, clr_q;
  logic [SW-1:0]  l_q, r_q;
  logic [EKW-1:0] k_q;
  // payload
  logic signed [AW-1:0]  a_q, na_q, ca_q;
  logic signed [BW-1:0]  b_q;
  logic signed [NBW-1:0] nb_q, cb_q;
  logic signed [XW-1:0]  xl_q, xc_q, xr_q;
  logic                  plus_q;
  logic [2:0]            flag_q;
  logic signed [VW-1:0]  vnew_q, prod_q, res_q, min_value_q;

  // geometry of node i
  logic [LVW-1:0]      lvl, sh;
  logic [NW-1:0]       span;
  logic [NW+LW-1:0]    ishift;
  logic [LW-1:0]       s;
  logic [NW-1:0]       pt_addr, n_used;
  logic                in_range;
  logic [LW-1:0]       coord_raddr, n_m1;
  logic [CRW-1:0]      coord_rd;
  logic signed [XW-1:0] coord_x;
  logic [NDW-1:0]      node_rd, node_wd;
  logic                node_we, coord_we, wr_new;
  logic [NW-1:0]       node_waddr;
  logic signed [AW-1:0]  sel_a;
  logic signed [NBW-1:0] sel_b;
  logic signed [XW-1:0]  sel_x;
  logic signed [AW+XW-1:0] prod_full;
  logic signed [VW-1:0]  val;
  logic fl, fc, fr, leaf, ins_done;
  logic [EW-1:0] end_sat;

  always_comb begin
    lvl = '0;
    for (int b = 0; b < NW; b++) begin
      if (i_q[b]) lvl = LVW'(b);
    end
  end
  assign sh     = LVW'(LW) - lvl;
  assign span   = NW'(1) << sh;
  assign ishift = (NW+LW)'(i_q) << sh;
  assign s      = ishift[LW-1:0];

  always_comb begin
    case (cmd_i.pt)
      PT_L:    pt_addr = NW'(s);
      PT_C:    pt_addr = NW'(s) + (span >> 1);
      PT_R:    pt_addr = NW'(s) + span;
      default: pt_addr = NW'(i_q[LW-1:0]);
    endcase
  end

  assign n_used      = (cc_q == '0) ? NW'(1) :
                       (cc_q > CW'(LEAVES)) ? NW'(LEAVES) : NW'(cc_q);
  assign n_m1        = LW'(n_used - NW'(1));
  assign in_range    = pt_addr < n_used;
  assign coord_raddr = in_range ? pt_addr[LW-1:0] : n_m1;
  assign coord_we    = (cmd_i.op == DP_ACCEPT) && (kind_i == KIND_LOAD);
  assign coord_x     = XW'($signed(coord_rd)) + XW'(plus_q);

  lct_ram #(.WIDTH(CRW), .DEPTH(LEAVES)) u_coord (
    .clk_i   (clk_i),
    .we_i    (coord_we),
    .waddr_i (slot_i),
    .wdata_i (coordinate_i),
    .raddr_i (coord_raddr),
    .rdata_o (coord_rd)
  );

  // evaluator operands
  assign sel_a = k_q[0] ? ca_q : na_q;
  assign sel_b = k_q[0] ? cb_q : nb_q;
  always_comb begin
    case (k_q[2:1])
      2'd0:    sel_x = xl_q;
      2'd1:    sel_x = xc_q;
      default: sel_x = xr_q;
    endcase
  end
  assign prod_full = sel_a * sel_x;
  assign val       = prod_q + VW'(sel_b);

  assign fl       = flag_q[0];
  assign fc       = flag_q[1];
  assign fr       = flag_q[2];
  assign leaf     = i_q[NW-1];
  assign ins_done = leaf || (fl == fr);
  assign wr_new   = leaf ? fl : ((fl && fr) || ((fl != fr) && fc));

  assign node_we    = (cmd_i.op == DP_CLEAR) || ((cmd_i.op == DP_DECIDE) && wr_new);
  assign node_waddr = (cmd_i.op == DP_CLEAR) ? clr_q : i_q;
  assign node_wd    = (cmd_i.op == DP_CLEAR) ? {AW'(0), NO_LINE[NBW-1:0]} : {na_q, nb_q};

  lct_ram #(.WIDTH(NDW), .DEPTH(2 * LEAVES)) u_node (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wd),
    .raddr_i (i_q),
    .rdata_o (node_rd)
  );

  assign end_sat = (end_slot_i > EW'(LEAVES)) ? EW'(LEAVES) : end_slot_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q  <= CW'(LEAVES);
      i_q   <= NW'(1);
      clr_q <= '0;
      l_q   <= '0;
      r_q   <= '0;
      k_q   <= '0;
    end else begin
      if (cc_we_i) cc_q <= cc_i;
      case (cmd_i.op)
        DP_CLEAR: clr_q <= clr_q + NW'(1);
        DP_ACCEPT: begin
          l_q <= SW'(slot_i) + SW'(LEAVES);
          r_q <= SW'(end_sat) + SW'(LEAVES);
          i_q <= (kind_i == KIND_QUERY) ? NW'(slot_i) + NW'(LEAVES) : NW'(1);
        end
        DP_INS_L: begin
          i_q <= l_q[NW-1:0];
          l_q <= l_q + SW'(1);
        end
        DP_INS_R: begin
          r_q <= r_q - SW'(1);
          i_q <= i_q ^ i_q ^ NW'(r_q - SW'(1));
        end
        DP_SHIFT: begin
          l_q <= l_q >> 1;
          r_q <= r_q >> 1;
        end
        DP_RD_NODE:  k_q <= '0;
        DP_CAP_NODE: k_q <= EKW'(1);
        DP_ADD:      k_q <= k_q + EKW'(1);
        DP_DECIDE: begin
          if (!ins_done) i_q <= {i_q[NW-2:0], fl == fc};
        end
        DP_QADD: i_q <= i_q >> 1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    plus_q <= !in_range;
    case (cmd_i.op)
      DP_ACCEPT: begin
        a_q   <= slope_i;
        b_q   <= intercept_i;
        na_q  <= slope_i;
        nb_q  <= NBW'(intercept_i);
        res_q <= NO_LINE;
      end
      DP_INS_L, DP_INS_R: begin
        na_q <= a_q;
        nb_q <= NBW'(b_q);
      end
      DP_CAP_XL: begin
        ca_q <= node_rd[NDW-1:NBW];
        cb_q <= node_rd[NBW-1:0];
        xl_q <= coord_x;
      end
      DP_CAP_XC: xc_q <= coord_x;
      DP_CAP_XR: xr_q <= coord_x;
      DP_CAP_Q:  xl_q <= coord_x;
      DP_CAP_NODE: begin
        ca_q <= node_rd[NDW-1:NBW];
        cb_q <= node_rd[NBW-1:0];
      end
      DP_MUL: prod_q <= prod_full[VW-1:0];
      DP_ADD: begin
        if (!k_q[0]) begin
          vnew_q <= val;
        end else begin
          case (k_q[2:1])
            2'd0:    flag_q[0] <= vnew_q < val;
            2'd1:    flag_q[1] <= vnew_q < val;
            default: flag_q[2] <= vnew_q < val;
          endcase
        end
      end
      DP_DECIDE: begin
        if (!ins_done && fc) begin
          na_q <= ca_q;
          nb_q <= cb_q;
        end
      end
      DP_QADD: begin
        if (val < res_q) res_q <= val;
      end
      DP_OUT: min_value_q <= res_q;
      default: ;
    endcase
  end

  assign sts_o.clr_last = (clr_q == NW'(2 * LEAVES - 1));
  assign sts_o.l_lt_r   = l_q < r_q;
  assign sts_o.l_odd    = l_q[0];
  assign sts_o.r_odd    = r_q[0];
  assign sts_o.k_last   = (k_q == EKW'(EVALS - 1));
  assign sts_o.ins_done = ins_done;
  assign sts_o.i_root   = (i_q == NW'(1));
  assign min_value_o    = min_value_q;

  `LCT_ASSERT(a_k_range, k_q <= EKW'(EVALS))
  `LCT_ASSERT(a_decide_node, (cmd_i.op == DP_DECIDE) |-> i_q != '0)
  `LCT_ASSERT_MSG(a_seg_left, (cmd_i.op == DP_INS_L) |-> l_q < r_q,
                  "left segment insert with empty range")
endmodule
`default_nettype wire

FILE: rtl/li_chao_min_line_tree_top.sv
// ----------------------------------------------------------------------------
// li_chao_min_line_tree_top
// Li Chao segment tree answering minimum-of-lines queries over loaded slots.
// ----------------------------------------------------------------------------
// After reset the node store is swept, one node a cycle, before the first
// transaction is taken. One item is processed at a time, all through a single
// 32x33 multiplier and one-write, one-read node and coordinate memories. A
// coordinate load is written as it is accepted. Each node visited by an
// insertion reads three coordinates and the node, then makes six line
// evaluations (multiply, then add) before deciding; a whole-domain line visits
// at most 11 nodes, a segment up to about 20 canonical nodes, each of which may
// descend to the leaves. A query walks from its leaf to the root, evaluating each
// node's line, and its result waits in an output register until taken.
`default_nettype none
module li_chao_min_line_tree_top (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    coord_count_we_i,
  input  wire logic [lct_pkg::CW-1:0]  coord_count_i,
  lct_in_if.sink                       in_if,
  lct_out_if.source                    out_if
);
  import lct_pkg::*;

  lct_cmd_t cmd;
  lct_sts_t sts;

  lct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_kind_i   (in_if.kind),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  lct_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cc_we_i      (coord_count_we_i),
    .cc_i         (coord_count_i),
    .kind_i       (in_if.kind),
    .slot_i       (in_if.slot),
    .end_slot_i   (in_if.end_slot),
    .slope_i      (in_if.slope),
    .intercept_i  (in_if.intercept),
    .coordinate_i (in_if.coordinate),
    .min_value_o  (out_if.min_value)
  );
endmodule
`default_nettype wire
